@@ rtl/core/vmbb_pkg.sv @@
`default_nettype none

package vmbb_pkg;

	localparam int VALUE_BITS_DEF = 16;
	localparam int INDEX_BITS_DEF = 12;
	localparam int NUM_AXES       = 3;
	localparam int COORD_W        = 32;
	localparam int CFG_DATA_W     = 32;
	localparam int BOUND_W        = 48;
	localparam int REG_IDX_W      = 3;

	localparam logic [COORD_W-1:0] SPACING_RESET = 32'h0001_0000;

	typedef enum logic [REG_IDX_W-1:0] {
		REG_BACKGROUND = 3'd0,
		REG_ORIGIN_X   = 3'd1,
		REG_ORIGIN_Y   = 3'd2,
		REG_ORIGIN_Z   = 3'd3,
		REG_SPACING_X  = 3'd4,
		REG_SPACING_Y  = 3'd5,
		REG_SPACING_Z  = 3'd6
	} reg_idx_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin;
		logic        [COORD_W-1:0] spacing;
	} axis_geom_t;

endpackage

`default_nettype wire

@@ rtl/core/vmbb_cfg.sv @@
`default_nettype none

module vmbb_cfg #(
	parameter int VALUE_BITS = vmbb_pkg::VALUE_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [vmbb_pkg::REG_IDX_W-1:0]         cfg_index,
	input  wire logic [vmbb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	output      logic [VALUE_BITS-1:0]                  background,
	output      vmbb_pkg::axis_geom_t                   geom [vmbb_pkg::NUM_AXES]
);
	import vmbb_pkg::*;

	logic [VALUE_BITS-1:0] background_q;
	axis_geom_t            geom_q [NUM_AXES];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			background_q <= '0;
			for (int a = 0; a < NUM_AXES; a++) begin
				geom_q[a].origin  <= '0;
				geom_q[a].spacing <= SPACING_RESET;
			end
		end else if (cfg_we) begin
			unique case (reg_idx_t'(cfg_index))
				REG_BACKGROUND: background_q       <= cfg_wdata[VALUE_BITS-1:0];
				REG_ORIGIN_X:   geom_q[0].origin   <= $signed(cfg_wdata);
				REG_ORIGIN_Y:   geom_q[1].origin   <= $signed(cfg_wdata);
				REG_ORIGIN_Z:   geom_q[2].origin   <= $signed(cfg_wdata);
				REG_SPACING_X:  geom_q[0].spacing  <= cfg_wdata;
				REG_SPACING_Y:  geom_q[1].spacing  <= cfg_wdata;
				REG_SPACING_Z:  geom_q[2].spacing  <= cfg_wdata;
				default: ;
			endcase
		end
	end

	assign background = background_q;
	assign geom       = geom_q;

endmodule

`default_nettype wire

@@ rtl/core/vmbb_track.sv @@
`default_nettype none

module vmbb_track #(
	parameter int VALUE_BITS = vmbb_pkg::VALUE_BITS_DEF,
	parameter int INDEX_BITS = vmbb_pkg::INDEX_BITS_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic [VALUE_BITS-1:0]        background,
	input  wire logic                         in_valid,
	output      logic                         in_ready,
	input  wire logic [VALUE_BITS-1:0]        voxel_value,
	input  wire logic [INDEX_BITS-1:0]        index [vmbb_pkg::NUM_AXES],
	input  wire logic                         last_voxel,
	output      logic                         box_valid,
	input  wire logic                         box_ready,
	output      logic                         box_found,
	output      logic signed [INDEX_BITS+1:0] k_lo [vmbb_pkg::NUM_AXES],
	output      logic signed [INDEX_BITS+1:0] k_hi [vmbb_pkg::NUM_AXES]
);
	import vmbb_pkg::*;

	localparam int K_W = INDEX_BITS + 2;

	logic                  valid_s1;
	logic [VALUE_BITS-1:0] value_s1;
	logic [INDEX_BITS-1:0] idx_s1 [NUM_AXES];
	logic                  last_s1;

	logic                  any_q;
	logic [INDEX_BITS-1:0] min_q [NUM_AXES];
	logic [INDEX_BITS-1:0] max_q [NUM_AXES];

	logic                  fg;
	logic                  any_nx;
	logic [INDEX_BITS-1:0] min_nx [NUM_AXES];
	logic [INDEX_BITS-1:0] max_nx [NUM_AXES];

	logic                  s1_go;
	logic                  s2_free;

	logic                  valid_s2;
	logic                  found_s2;
	logic signed [K_W-1:0] k_lo_s2 [NUM_AXES];
	logic signed [K_W-1:0] k_hi_s2 [NUM_AXES];

	// a last item in s1 waits only when the box register is still held
	assign s2_free  = !valid_s2 || box_ready;
	assign s1_go    = valid_s1 && (!last_s1 || s2_free);
	assign in_ready = !valid_s1 || s1_go;

	always_comb begin
		fg     = (value_s1 != background);
		any_nx = any_q || fg;
		for (int a = 0; a < NUM_AXES; a++) begin
			min_nx[a] = min_q[a];
			max_nx[a] = max_q[a];
			if (fg) begin
				if (!any_q || (idx_s1[a] < min_q[a])) min_nx[a] = idx_s1[a];
				if (!any_q || (idx_s1[a] > max_q[a])) max_nx[a] = idx_s1[a];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			value_s1 <= voxel_value;
			idx_s1   <= index;
			last_s1  <= last_voxel;
		end
	end

	// running extrema: fold in on every item, drop after a last item
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			any_q <= 1'b0;
			for (int a = 0; a < NUM_AXES; a++) begin
				min_q[a] <= '0;
				max_q[a] <= '0;
			end
		end else if (s1_go) begin
			if (last_s1) begin
				any_q <= 1'b0;
				for (int a = 0; a < NUM_AXES; a++) begin
					min_q[a] <= '0;
					max_q[a] <= '0;
				end
			end else begin
				any_q  <= any_nx;
				min_q  <= min_nx;
				max_q  <= max_nx;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (s2_free) begin
			valid_s2 <= s1_go && last_s1;
		end
	end

	// odd multiples of half a voxel: 2*min-1 and 2*max+1
	always_ff @(posedge clk) begin
		if (s2_free && s1_go && last_s1) begin
			found_s2 <= any_nx;
			for (int a = 0; a < NUM_AXES; a++) begin
				k_lo_s2[a] <= $signed({1'b0, min_nx[a], 1'b0}) - $signed(K_W'(1));
				k_hi_s2[a] <= $signed({1'b0, max_nx[a], 1'b1});
			end
		end
	end

	assign box_valid = valid_s2;
	assign box_found = found_s2;
	assign k_lo      = k_lo_s2;
	assign k_hi      = k_hi_s2;

`ifndef ASSERT_OFF
	a_clear_after_last: assert property (@(posedge clk) disable iff (!arst_n)
		s1_go && last_s1 |=> !any_q)
		else $error("extrema not cleared after last item");

	a_min_le_max: assert property (@(posedge clk) disable iff (!arst_n)
		any_q |-> (min_q[0] <= max_q[0]) && (min_q[1] <= max_q[1]) && (min_q[2] <= max_q[2]))
		else $error("running minimum above maximum");

	a_box_order: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s2 && found_s2 |-> (k_lo_s2[0] < k_hi_s2[0]) && (k_lo_s2[1] < k_hi_s2[1])
			&& (k_lo_s2[2] < k_hi_s2[2]))
		else $error("box lower multiple not below upper multiple");
`endif

endmodule

`default_nettype wire

@@ rtl/core/vmbb_bound.sv @@
`default_nettype none

module vmbb_bound #(
	parameter int INDEX_BITS = vmbb_pkg::INDEX_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire vmbb_pkg::axis_geom_t                   geom [vmbb_pkg::NUM_AXES],
	input  wire logic                                   in_valid,
	output      logic                                   in_ready,
	input  wire logic                                   in_found,
	input  wire logic signed [INDEX_BITS+1:0]           k_lo [vmbb_pkg::NUM_AXES],
	input  wire logic signed [INDEX_BITS+1:0]           k_hi [vmbb_pkg::NUM_AXES],
	output      logic                                   out_valid,
	input  wire logic                                   out_ready,
	output      logic                                   found,
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    lower [vmbb_pkg::NUM_AXES],
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    upper [vmbb_pkg::NUM_AXES]
);
	import vmbb_pkg::*;

	localparam int K_W = INDEX_BITS + 2;
	localparam int PW  = K_W + COORD_W + 1;
	localparam int NW  = PW + 1;
	localparam int EW  = (PW > BOUND_W) ? PW : BOUND_W;

	localparam logic signed [EW-1:0] B_MAX =
		$signed({{(EW-BOUND_W+1){1'b0}}, {(BOUND_W-1){1'b1}}});
	localparam logic signed [EW-1:0] B_MIN =
		$signed({{(EW-BOUND_W+1){1'b1}}, {(BOUND_W-1){1'b0}}});

	// floor((2*origin + prod) / 2), clamped to the bound range
	function automatic logic signed [BOUND_W-1:0] finish(
		input logic signed [PW-1:0]      prod,
		input logic signed [COORD_W-1:0] origin
	);
		logic signed [NW-1:0] num;
		logic signed [EW-1:0] q;
		logic signed [BOUND_W-1:0] r;
		num = NW'(prod) + NW'($signed({origin, 1'b0}));
		q   = EW'($signed(num[NW-1:1]));
		if (q > B_MAX)      r = B_MAX[BOUND_W-1:0];
		else if (q < B_MIN) r = B_MIN[BOUND_W-1:0];
		else                r = q[BOUND_W-1:0];
		return r;
	endfunction

	logic                 valid_s3;
	logic                 found_s3;
	logic signed [PW-1:0] lo_prod_s3 [NUM_AXES];
	logic signed [PW-1:0] hi_prod_s3 [NUM_AXES];

	logic                       valid_s4;
	logic                       found_s4;
	logic signed [BOUND_W-1:0]  lower_s4 [NUM_AXES];
	logic signed [BOUND_W-1:0]  upper_s4 [NUM_AXES];

	logic out_free;

	assign out_free = !valid_s4 || out_ready;
	assign in_ready = !valid_s3 || out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
		end else if (in_ready) begin
			valid_s3 <= in_valid;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s4 <= 1'b0;
		end else if (out_free) begin
			valid_s4 <= valid_s3;
		end
	end

	always_ff @(posedge clk) begin
		if (in_valid && in_ready) begin
			found_s3 <= in_found;
		end
		if (valid_s3 && out_free) begin
			found_s4 <= found_s3;
		end
	end

	for (genvar a = 0; a < NUM_AXES; a++) begin : g_axis
		logic signed [COORD_W:0] spacing_sx;

		assign spacing_sx = $signed({1'b0, geom[a].spacing});

		always_ff @(posedge clk) begin
			if (in_valid && in_ready) begin
				lo_prod_s3[a] <= PW'(k_lo[a]) * PW'(spacing_sx);
				hi_prod_s3[a] <= PW'(k_hi[a]) * PW'(spacing_sx);
			end
		end

		always_ff @(posedge clk) begin
			if (valid_s3 && out_free) begin
				lower_s4[a] <= found_s3 ? finish(lo_prod_s3[a], geom[a].origin) : '0;
				upper_s4[a] <= found_s3 ? finish(hi_prod_s3[a], geom[a].origin) : '0;
			end
		end
	end

	assign out_valid = valid_s4;
	assign found     = found_s4;
	assign lower     = lower_s4;
	assign upper     = upper_s4;

`ifndef ASSERT_OFF
	a_s3_hold: assert property (@(posedge clk) disable iff (!arst_n)
		valid_s3 && valid_s4 && !out_ready |=> valid_s3 && $stable(found_s3))
		else $error("product stage lost an item while output held");
`endif

endmodule

`default_nettype wire

@@ rtl/core/voxel_mask_bounding_box_top.sv @@
`default_nettype none

// Voxel mask bounding box. Stream voxels in (value plus x, y, z index), one item per
// clock at full rate; every voxel whose value differs from background_value widens a
// running per-axis box of indices. The voxel flagged last_voxel (counted itself) closes
// the image: one result item comes out carrying found and, per axis, the physical
// bounds lower = origin + min*spacing - spacing/2 and upper = origin + (max+1)*spacing
// - spacing/2 in signed Q32.16 on 48 bits, rounded toward minus infinity and clamped.
// With no foreground, found is 0 and all bounds read 0. The box is cleared after every
// result. Voxels that are not last produce nothing. Once its last voxel is accepted, a
// result item passes through the input register, box register, product register and
// output register; the depth is set by the six index-by-spacing multipliers
// (about 14 by 33 bits at the default index width), each followed by a register before
// the origin add and clamp. in_ready drops only while a last voxel waits in the input
// register behind a result path that is full, so out_ready stalls reach the input only
// after a result is stuck. Write configuration only while the block is idle; writes to
// register indexes beyond spacing_z are dropped.
module voxel_mask_bounding_box_top #(
	parameter int VALUE_BITS = vmbb_pkg::VALUE_BITS_DEF,
	parameter int INDEX_BITS = vmbb_pkg::INDEX_BITS_DEF
) (
	input  wire logic                                   clk,
	input  wire logic                                   arst_n,
	input  wire logic                                   cfg_we,
	input  wire logic [vmbb_pkg::REG_IDX_W-1:0]         cfg_index,
	input  wire logic [vmbb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
	input  wire logic                                   in_valid,
	output      logic                                   in_ready,
	input  wire logic [VALUE_BITS-1:0]                  voxel_value,
	input  wire logic [INDEX_BITS-1:0]                  index_x,
	input  wire logic [INDEX_BITS-1:0]                  index_y,
	input  wire logic [INDEX_BITS-1:0]                  index_z,
	input  wire logic                                   last_voxel,
	output      logic                                   out_valid,
	input  wire logic                                   out_ready,
	output      logic                                   found,
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    lower_x,
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    upper_x,
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    lower_y,
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    upper_y,
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    lower_z,
	output      logic signed [vmbb_pkg::BOUND_W-1:0]    upper_z
);
	import vmbb_pkg::*;

	localparam int K_W = INDEX_BITS + 2;

	logic [VALUE_BITS-1:0]      background;
	axis_geom_t                 geom [NUM_AXES];

	logic [INDEX_BITS-1:0]      index [NUM_AXES];

	// box handoff from the tracker to the bound pipeline
	logic                       box_valid;
	logic                       box_ready;
	logic                       box_found;
	logic signed [K_W-1:0]      k_lo [NUM_AXES];
	logic signed [K_W-1:0]      k_hi [NUM_AXES];

	logic signed [BOUND_W-1:0]  lower [NUM_AXES];
	logic signed [BOUND_W-1:0]  upper [NUM_AXES];

	assign index[0] = index_x;
	assign index[1] = index_y;
	assign index[2] = index_z;

	// configuration registers: background value, per-axis origin and spacing
	vmbb_cfg #(
		.VALUE_BITS (VALUE_BITS)
	) u_cfg (
		.clk        (clk),
		.arst_n     (arst_n),
		.cfg_we     (cfg_we),
		.cfg_index  (cfg_index),
		.cfg_wdata  (cfg_wdata),
		.background (background),
		.geom       (geom)
	);

	// input register and running per-axis extrema
	vmbb_track #(
		.VALUE_BITS (VALUE_BITS),
		.INDEX_BITS (INDEX_BITS)
	) u_track (
		.clk         (clk),
		.arst_n      (arst_n),
		.background  (background),
		.in_valid    (in_valid),
		.in_ready    (in_ready),
		.voxel_value (voxel_value),
		.index       (index),
		.last_voxel  (last_voxel),
		.box_valid   (box_valid),
		.box_ready   (box_ready),
		.box_found   (box_found),
		.k_lo        (k_lo),
		.k_hi        (k_hi)
	);

	// scale by spacing, add origin, round and clamp, hold for the consumer
	vmbb_bound #(
		.INDEX_BITS (INDEX_BITS)
	) u_bound (
		.clk       (clk),
		.arst_n    (arst_n),
		.geom      (geom),
		.in_valid  (box_valid),
		.in_ready  (box_ready),
		.in_found  (box_found),
		.k_lo      (k_lo),
		.k_hi      (k_hi),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.found     (found),
		.lower     (lower),
		.upper     (upper)
	);

	assign lower_x = lower[0];
	assign upper_x = upper[0];
	assign lower_y = lower[1];
	assign upper_y = upper[1];
	assign lower_z = lower[2];
	assign upper_z = upper[2];

endmodule

`default_nettype wire
